### src/assert_macros.svh
// assertion helpers for the price level book
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### src/plbu_pkg.sv
// ----------------------------------------------------------------------------
// plbu_pkg
// types and constants for the price level book update unit
// ----------------------------------------------------------------------------
`default_nettype none
package plbu_pkg;
  localparam int unsigned LevelDepth = 64;
  localparam int unsigned PriceBits  = 32;
  localparam int unsigned VolumeBits = 32;
  localparam int unsigned IdxBits    = $clog2(LevelDepth);
  localparam int unsigned CntBits    = $clog2(LevelDepth + 1);

  typedef enum logic [2:0] {
    StInserted       = 3'd0,
    StReplaced       = 3'd1,
    StRemoved        = 3'd2,
    StRemoveIgnored  = 3'd3,
    StWorstDropped   = 3'd4,
    StInsertDropped  = 3'd5,
    StCleared        = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    KindUpdate = 2'd0,
    KindClear  = 2'd1
  } kind_e;

  typedef struct packed {
    logic                  operation;
    logic                  side;
    logic [PriceBits-1:0]  price_ticks;
    logic [VolumeBits-1:0] volume_lots;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [PriceBits-1:0]  best_bid_price;
    logic [VolumeBits-1:0] best_bid_volume;
    logic [PriceBits-1:0]  best_ask_price;
    logic [VolumeBits-1:0] best_ask_volume;
    logic [CntBits-1:0]    bid_levels;
    logic [CntBits-1:0]    ask_levels;
  } rsp_t;

  // classified command passed from front to back
  typedef struct packed {
    kind_e                 kind;
    logic                  side;
    logic [PriceBits-1:0]  price;
    logic [VolumeBits-1:0] volume;
    logic                  vol_zero;
  } cmd_t;
endpackage
`default_nettype wire

### src/plbu_front.sv
// ----------------------------------------------------------------------------
// plbu_front
// accepts words, classifies them and holds a two entry command queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module plbu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  plbu_pkg::req_t     req_i,
  output logic               busy_o,
  output logic               cmd_valid_o,
  output plbu_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);
  import plbu_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_new;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    cmd_new.kind     = req_i.operation ? KindClear : KindUpdate;
    cmd_new.side     = req_i.side;
    cmd_new.price    = req_i.price_ticks;
    cmd_new.volume   = req_i.volume_lots;
    cmd_new.vol_zero = (req_i.volume_lots == '0);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  `ASSERT_CLK(pop_nonempty, clk_i, rst_ni, cmd_pop_i |-> cmd_valid_o, "pop of empty queue")
  `ASSERT_CLK(cnt_bound, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")
  `ASSERT_CLK(full_blocks, clk_i, rst_ni,
              (cnt_q == 2'd2 && !cmd_pop_i) |=> cnt_q == 2'd2, "full queue lost a word")
endmodule
`default_nettype wire

### src/plbu_back.sv
// ----------------------------------------------------------------------------
// plbu_back
// sorted level tables as compare and shift cells; a new word enters only when none is in the shift stage
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module plbu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  plbu_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               done_o,
  output plbu_pkg::rsp_t     rsp_o
);
  import plbu_pkg::*;

  logic [PriceBits-1:0]  bp_q [LevelDepth];
  logic [VolumeBits-1:0] bv_q [LevelDepth];
  logic [PriceBits-1:0]  ap_q [LevelDepth];
  logic [VolumeBits-1:0] av_q [LevelDepth];
  logic [CntBits-1:0]    bcnt_q, acnt_q;

  // stage one registers: compare vectors
  logic                  s1_q;
  cmd_t                  c1_q;
  logic [LevelDepth-1:0] before_q, equal_q;

  logic [LevelDepth-1:0] before_d, equal_d;
  logic [CntBits-1:0]    ncur;

  assign cmd_pop_o = cmd_valid_i && !s1_q;
  assign ncur      = cmd_i.side ? acnt_q : bcnt_q;

  always_comb begin
    for (int i = 0; i < LevelDepth; i++) begin
      logic [PriceBits-1:0] tp;
      logic                 live;
      tp   = cmd_i.side ? ap_q[i] : bp_q[i];
      live = (CntBits'(i) < ncur);
      before_d[i] = live && (cmd_i.side ? (tp < cmd_i.price) : (tp > cmd_i.price));
      equal_d[i]  = live && (tp == cmd_i.price);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else begin
      s1_q <= cmd_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      c1_q     <= cmd_i;
      before_q <= before_d;
      equal_q  <= equal_d;
    end
  end

  // stage two: decide and shift
  logic [CntBits-1:0]    n2, pos, cnt_new;
  logic                  found, full, do_ins, do_rem, do_rep;
  status_e               st;

  always_comb begin
    n2  = c1_q.side ? acnt_q : bcnt_q;
    pos = CntBits'($countones(before_q));
    found = |equal_q;
    full  = (n2 == CntBits'(LevelDepth));
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_rep = 1'b0;
    cnt_new = n2;
    if (found) begin
      if (c1_q.vol_zero) begin
        do_rem = 1'b1; st = StRemoved; cnt_new = n2 - CntBits'(1);
      end else begin
        do_rep = 1'b1; st = StReplaced;
      end
    end else if (c1_q.vol_zero) begin
      st = StRemoveIgnored;
    end else if (full) begin
      if (pos == CntBits'(LevelDepth)) begin
        st = StInsertDropped;
      end else begin
        do_ins = 1'b1; st = StWorstDropped;
      end
    end else begin
      do_ins = 1'b1; st = StInserted; cnt_new = n2 + CntBits'(1);
    end
    if (c1_q.kind == KindClear) begin
      st = StCleared; do_ins = 1'b0; do_rem = 1'b0; do_rep = 1'b0;
    end
  end

  logic upd;
  assign upd = s1_q && (c1_q.kind == KindUpdate);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
      acnt_q <= '0;
    end else if (s1_q) begin
      if (c1_q.kind == KindClear) begin
        bcnt_q <= '0;
        acnt_q <= '0;
      end else if (c1_q.side) begin
        acnt_q <= cnt_new;
      end else begin
        bcnt_q <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LevelDepth; i++) begin
      logic [CntBits-1:0] ci;
      ci = CntBits'(i);
      if (upd && !c1_q.side) begin
        if ((do_ins && ci == pos) || (do_rep && equal_q[i])) begin
          bp_q[i] <= c1_q.price;
          bv_q[i] <= c1_q.volume;
        end else if (do_ins && ci > pos) begin
          bp_q[i] <= bp_q[i-1];
          bv_q[i] <= bv_q[i-1];
        end else if (do_rem && ci >= pos && i < LevelDepth - 1) begin
          bp_q[i] <= bp_q[i+1];
          bv_q[i] <= bv_q[i+1];
        end
      end
      if (upd && c1_q.side) begin
        if ((do_ins && ci == pos) || (do_rep && equal_q[i])) begin
          ap_q[i] <= c1_q.price;
          av_q[i] <= c1_q.volume;
        end else if (do_ins && ci > pos) begin
          ap_q[i] <= ap_q[i-1];
          av_q[i] <= av_q[i-1];
        end else if (do_rem && ci >= pos && i < LevelDepth - 1) begin
          ap_q[i] <= ap_q[i+1];
          av_q[i] <= av_q[i+1];
        end
      end
    end
  end

  // result register, best fields read from updated tables next cycle
  logic      done_q;
  logic [2:0] st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      st_q <= st;
    end
  end

  assign done_o                = done_q;
  assign rsp_o.status          = st_q;
  assign rsp_o.best_bid_price  = (bcnt_q != '0) ? bp_q[0] : '0;
  assign rsp_o.best_bid_volume = (bcnt_q != '0) ? bv_q[0] : '0;
  assign rsp_o.best_ask_price  = (acnt_q != '0) ? ap_q[0] : '0;
  assign rsp_o.best_ask_volume = (acnt_q != '0) ? av_q[0] : '0;
  assign rsp_o.bid_levels      = bcnt_q;
  assign rsp_o.ask_levels      = acnt_q;

  `ASSERT_CLK(bid_cnt_max, clk_i, rst_ni, bcnt_q <= CntBits'(LevelDepth), "bid count overflow")
  `ASSERT_CLK(ask_cnt_max, clk_i, rst_ni, acnt_q <= CntBits'(LevelDepth), "ask count overflow")
  `ASSERT_CLK(one_in_flight, clk_i, rst_ni, s1_q |-> !cmd_pop_o, "second word entered early")
  `ASSERT_CLK(done_follows, clk_i, rst_ni, s1_q |=> done_o, "result strobe missing")
endmodule
`default_nettype wire

### src/price_level_book_update_unit.sv
// ----------------------------------------------------------------------------
// price_level_book_update_unit
// sorted bid and ask price level tables updated one word at a time
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// input    | start_i, busy_o    | req_i
// result   | done_o (strobe)    | rsp_o
//
// a word passes the back end in order: compare, then shift and write;
// the result strobe is high in the cycle after the shift and write.
// a new word enters the back end only once the word before has left the shift stage,
// since its compare must see the tables written by the word before.
// a two word queue holds words in front; busy_o is high only while it is full.
// reset clears the counts and the queue; table contents need no clearing.
// the receiver cannot stall the result.
`default_nettype none
module price_level_book_update_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  plbu_pkg::req_t     req_i,
  output logic               busy_o,
  output logic               done_o,
  output plbu_pkg::rsp_t     rsp_o
);
  import plbu_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  plbu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  plbu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );
endmodule
`default_nettype wire

### tb/tb_price_level_book_update_unit.sv
// ----------------------------------------------------------------------------
// tb_price_level_book_update_unit
// drives updates and clears into both price level tables and checks every
// result word against a sorted book kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_price_level_book_update_unit;
  import plbu_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  price_level_book_update_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // book copy: index 0 is the best level
  logic [PriceBits-1:0]  bid_px [LevelDepth];
  logic [VolumeBits-1:0] bid_vol[LevelDepth];
  logic [PriceBits-1:0]  ask_px [LevelDepth];
  logic [VolumeBits-1:0] ask_vol[LevelDepth];
  int unsigned n_bid = 0, n_ask = 0;

  req_t pending_words[$];
  rsp_t expected_books[$];
  int unsigned errors = 0, n_checked = 0, cycles = 0, n_sent = 0;
  int unsigned status_seen[7];
  int unsigned gap = 0;

  function automatic status_e apply_level(input logic is_ask,
      input logic [PriceBits-1:0] p, input logic [VolumeBits-1:0] v);
    int unsigned n, pos;
    logic better;
    n = is_ask ? n_ask : n_bid;
    pos = 0;
    while (pos < n) begin
      if (is_ask) better = ask_px[pos] < p;
      else better = bid_px[pos] > p;
      if (!better) break;
      pos++;
    end
    if (pos < n && (is_ask ? ask_px[pos] : bid_px[pos]) == p) begin
      if (v == '0) begin
        for (int i = pos; i < n - 1; i++) begin
          if (is_ask) begin
            ask_px[i] = ask_px[i+1]; ask_vol[i] = ask_vol[i+1];
          end else begin
            bid_px[i] = bid_px[i+1]; bid_vol[i] = bid_vol[i+1];
          end
        end
        if (is_ask) n_ask = n - 1; else n_bid = n - 1;
        return StRemoved;
      end
      if (is_ask) ask_vol[pos] = v; else bid_vol[pos] = v;
      return StReplaced;
    end
    if (v == '0) return StRemoveIgnored;
    if (n >= LevelDepth && pos >= LevelDepth) return StInsertDropped;
    for (int i = ((n >= LevelDepth) ? LevelDepth - 1 : n); i > int'(pos); i--) begin
      if (is_ask) begin
        ask_px[i] = ask_px[i-1]; ask_vol[i] = ask_vol[i-1];
      end else begin
        bid_px[i] = bid_px[i-1]; bid_vol[i] = bid_vol[i-1];
      end
    end
    if (is_ask) begin
      ask_px[pos] = p; ask_vol[pos] = v;
    end else begin
      bid_px[pos] = p; bid_vol[pos] = v;
    end
    if (n >= LevelDepth) return StWorstDropped;
    if (is_ask) n_ask = n + 1; else n_bid = n + 1;
    return StInserted;
  endfunction

  function automatic rsp_t book_after(input req_t w);
    rsp_t r;
    if (w.operation) begin
      n_bid = 0; n_ask = 0;
      r.status = StCleared;
    end else begin
      r.status = apply_level(w.side, w.price_ticks, w.volume_lots);
    end
    r.best_bid_price  = n_bid ? bid_px[0] : '0;
    r.best_bid_volume = n_bid ? bid_vol[0] : '0;
    r.best_ask_price  = n_ask ? ask_px[0] : '0;
    r.best_ask_volume = n_ask ? ask_vol[0] : '0;
    r.bid_levels = CntBits'(n_bid);
    r.ask_levels = CntBits'(n_ask);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want, n_checked);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_books.push_back(book_after(req_i));
        n_sent++;
        gap = pick_gap();
      end else if (!start_i && gap > 0) begin
        gap--;
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap == 0 && pending_words.size() > 0 &&
                   !(start_i && !busy_o && gap != 0)) begin
        start_i <= 1'b1;
        req_i <= pending_words.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t e;
    cycles++;
    if (rst_ni && done_o) begin
      if (expected_books.size() == 0) begin
        errors++;
        $display("result word with nothing expected");
      end else begin
        e = expected_books.pop_front();
        if (rsp_o.status <= 6) status_seen[rsp_o.status]++;
        if (rsp_o.status !== e.status) report_mismatch("status", rsp_o.status, e.status);
        if (rsp_o.best_bid_price !== e.best_bid_price)
          report_mismatch("best_bid_price", rsp_o.best_bid_price, e.best_bid_price);
        if (rsp_o.best_bid_volume !== e.best_bid_volume)
          report_mismatch("best_bid_volume", rsp_o.best_bid_volume, e.best_bid_volume);
        if (rsp_o.best_ask_price !== e.best_ask_price)
          report_mismatch("best_ask_price", rsp_o.best_ask_price, e.best_ask_price);
        if (rsp_o.best_ask_volume !== e.best_ask_volume)
          report_mismatch("best_ask_volume", rsp_o.best_ask_volume, e.best_ask_volume);
        if (rsp_o.bid_levels !== e.bid_levels)
          report_mismatch("bid_levels", rsp_o.bid_levels, e.bid_levels);
        if (rsp_o.ask_levels !== e.ask_levels)
          report_mismatch("ask_levels", rsp_o.ask_levels, e.ask_levels);
        n_checked++;
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic req_t make_word(input logic op, input logic sd,
      input logic [31:0] p, input logic [31:0] v);
    req_t w;
    w.operation = op; w.side = sd; w.price_ticks = p; w.volume_lots = v;
    return w;
  endfunction

  function automatic logic [31:0] rand_vol();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'hFFFF_FFFF;
    if (r < 3) return $urandom;
    return $urandom_range(1, 1000);
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || start_i || expected_books.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic sd;
    logic [31:0] base, p;
    int unsigned mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, replace, remove, ignored remove, clear
    pending_words.push_back(make_word(0, 0, 32'h0, 32'h1));
    pending_words.push_back(make_word(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(0, 1, 32'hFFFF_FFFF, 32'h5));
    pending_words.push_back(make_word(0, 1, 32'h0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(0, 1, 32'h1234, 32'h7));
    pending_words.push_back(make_word(0, 0, 32'h0, 32'hAAAA_5555));
    pending_words.push_back(make_word(0, 1, 32'h0, 32'h0));
    pending_words.push_back(make_word(0, 0, 32'h55, 32'h0));
    pending_words.push_back(make_word(0, 0, 32'hFFFF_FFFF, 32'h0));
    pending_words.push_back(make_word(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(0, 1, 32'h10, 32'h0));
    wait_drained();

    // fill both tables, then overflow from both ends
    for (int i = 0; i < LevelDepth; i++) begin
      pending_words.push_back(make_word(0, 0, 32'd1000 + 2 * i, i + 1));
      pending_words.push_back(make_word(0, 1, 32'd1000 + 2 * i, i + 1));
    end
    pending_words.push_back(make_word(0, 0, 32'd999, 32'h9));
    pending_words.push_back(make_word(0, 1, 32'd2000, 32'h9));
    pending_words.push_back(make_word(0, 0, 32'd1001, 32'h9));
    pending_words.push_back(make_word(0, 1, 32'd1001, 32'h9));
    pending_words.push_back(make_word(0, 0, 32'd5000, 32'h9));
    pending_words.push_back(make_word(0, 1, 32'd3, 32'h9));
    pending_words.push_back(make_word(1, 0, 32'd0, 32'h0));

    // random: clustered prices so levels recur, occasional clears and random prices
    base = 32'd50000;
    for (int i = 0; i < 1500; i++) begin
      mode = $urandom_range(0, 99);
      sd = $urandom_range(0, 1);
      if (mode < 2) begin
        pending_words.push_back(make_word(1, sd, $urandom, $urandom));
        base = $urandom_range(100, 32'h7FFF_FFFF);
      end else if (mode < 6) begin
        pending_words.push_back(make_word(0, sd, $urandom, rand_vol()));
      end else begin
        p = base + $urandom_range(0, 90) - 45;
        pending_words.push_back(make_word(0, sd, p,
          ($urandom_range(0, 3) == 0) ? 32'h0 : rand_vol()));
      end
      // sender pauses here until every expected result is back
      if (i == 700) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("sent %0d words, checked %0d results", n_sent, n_checked);
    $display("status mix ins/rep/rem/ign/wdrop/idrop/clr: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
      status_seen[0], status_seen[1], status_seen[2], status_seen[3],
      status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0 && expected_books.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
